[design/csa_pkg.sv]
// ----------------------------------------------------------------------------
// csa_pkg: shared types and codes for the checked signed ALU
// Operation and status codes, default width, and the control word that
// travels along the divider cell row.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int WIDTH_DEF = 32;
  localparam int MODE_W    = 3;
  localparam int ST_W      = 2;

  localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REM = 3'd4;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_OVF  = 2'd1;
  localparam logic [ST_W-1:0] ST_DIVZ = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [MODE_W-1:0] mode;
    logic              neg_q;
    logic              neg_r;
    logic [ST_W-1:0]   status;
  } csa_ctl_t;

endpackage

[design/csa_div_cell.sv]
// ----------------------------------------------------------------------------
// csa_div_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits, and hands the word on to the next cell.
// ----------------------------------------------------------------------------
module csa_div_cell #(
  parameter int WIDTH = csa_pkg::WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  csa_pkg::csa_ctl_t ctl_in,
  input  logic [WIDTH-1:0]  rem_in,
  input  logic [WIDTH-1:0]  quo_in,
  input  logic [WIDTH-1:0]  dsr_in,
  input  logic [WIDTH-1:0]  early_in,
  output csa_pkg::csa_ctl_t ctl,
  output logic [WIDTH-1:0]  rem,
  output logic [WIDTH-1:0]  quo,
  output logic [WIDTH-1:0]  dsr,
  output logic [WIDTH-1:0]  early
);
  import csa_pkg::*;

  logic [WIDTH-1:0] shifted;
  logic             fits;
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH-1:0] quo_next;

  always_comb begin
    shifted  = {rem_in[WIDTH-2:0], quo_in[WIDTH-1]};
    fits     = shifted >= dsr_in;
    rem_next = fits ? shifted - dsr_in : shifted;
    quo_next = {quo_in[WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
    if (en) begin
      rem   <= rem_next;
      quo   <= quo_next;
      dsr   <= dsr_in;
      early <= early_in;
    end
  end

endmodule

[design/checked_signed_alu.sv]
// Pipeline: WIDTH+3 register stages (input register, prepare stage, one division cell
// per operand bit, output register); the input register loads at the accepting edge.
// Throughput: one word per cycle; the whole pipeline holds only while an
// output word waits and m_axis_tready is low.
// Reset: rst (synchronous) clears all valid flags; data registers keep values.
// ----------------------------------------------------------------------------
// checked_signed_alu: overflow-checked signed integer ALU
// Add, subtract, multiply, truncating divide and remainder with overflow and
// divide-by-zero status; division runs through a row of restoring cells.
// ----------------------------------------------------------------------------
module checked_signed_alu #(
  parameter int WIDTH = csa_pkg::WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // operand_a, operand_b
  input  logic [((2*WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  // mode
  input  logic [csa_pkg::MODE_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // value
  output logic [((WIDTH+7)/8)*8-1:0]        m_axis_tdata,
  // status
  output logic [csa_pkg::ST_W-1:0]          m_axis_tuser
);
  import csa_pkg::*;

  localparam int OUT_W = ((WIDTH+7)/8)*8;

  logic                adv;
  logic                v0;
  logic [MODE_W-1:0]   mode0;
  logic [WIDTH-1:0]    a0;
  logic [WIDTH-1:0]    b0;
  logic [2*WIDTH-1:0]  p0;

  csa_ctl_t            ctl1_next;
  logic [WIDTH-1:0]    early1_next;
  logic [WIDTH-1:0]    ma;
  logic [WIDTH-1:0]    mb;
  logic [WIDTH-1:0]    sum;
  logic [WIDTH-1:0]    diff;

  csa_ctl_t            ctl1;
  logic [WIDTH-1:0]    quo1;
  logic [WIDTH-1:0]    dsr1;
  logic [WIDTH-1:0]    early1;

  csa_ctl_t            cell_ctl   [WIDTH+1];
  logic [WIDTH-1:0]    cell_rem   [WIDTH+1];
  logic [WIDTH-1:0]    cell_quo   [WIDTH+1];
  logic [WIDTH-1:0]    cell_dsr   [WIDTH+1];
  logic [WIDTH-1:0]    cell_early [WIDTH+1];

  csa_ctl_t            fin;
  logic [WIDTH-1:0]    value_next;
  logic [WIDTH-1:0]    value;
  logic [ST_W-1:0]     status;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_axis_tvalid;
    end
    if (adv) begin
      mode0 <= s_axis_tuser;
      a0    <= s_axis_tdata[WIDTH-1:0];
      b0    <= s_axis_tdata[2*WIDTH-1:WIDTH];
      p0    <= (2*WIDTH)'($signed(s_axis_tdata[WIDTH-1:0]) *
                          $signed(s_axis_tdata[2*WIDTH-1:WIDTH]));
    end
  end

  always_comb begin
    ma   = a0[WIDTH-1] ? -a0 : a0;
    mb   = b0[WIDTH-1] ? -b0 : b0;
    sum  = a0 + b0;
    diff = a0 - b0;
    ctl1_next        = '0;
    ctl1_next.valid  = v0;
    ctl1_next.mode   = mode0;
    ctl1_next.neg_q  = a0[WIDTH-1] ^ b0[WIDTH-1];
    ctl1_next.neg_r  = a0[WIDTH-1];
    ctl1_next.status = ST_OK;
    early1_next      = '0;
    case (mode0)
      MODE_ADD: begin
        early1_next = sum;
        if (((a0 ^ sum) & (b0 ^ sum)) >> (WIDTH-1) != '0) ctl1_next.status = ST_OVF;
      end
      MODE_SUB: begin
        early1_next = diff;
        if (((a0 ^ b0) & (a0 ^ diff)) >> (WIDTH-1) != '0) ctl1_next.status = ST_OVF;
      end
      MODE_MUL: begin
        early1_next = p0[WIDTH-1:0];
        if (!(&p0[2*WIDTH-1:WIDTH-1]) && (|p0[2*WIDTH-1:WIDTH-1]))
          ctl1_next.status = ST_OVF;
      end
      MODE_DIV, MODE_REM: begin
        if (b0 == '0) begin
          ctl1_next.status = ST_DIVZ;
        end else if (mode0 == MODE_DIV && a0 == {1'b1, {(WIDTH-1){1'b0}}} && (&b0)) begin
          ctl1_next.status = ST_OVF;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else if (adv) begin
      ctl1 <= ctl1_next;
    end
    if (adv) begin
      quo1   <= ma;
      dsr1   <= mb;
      early1 <= early1_next;
    end
  end

  assign cell_ctl[0]   = ctl1;
  assign cell_rem[0]   = '0;
  assign cell_quo[0]   = quo1;
  assign cell_dsr[0]   = dsr1;
  assign cell_early[0] = early1;

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    csa_div_cell #(.WIDTH(WIDTH)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .ctl_in   (cell_ctl[i]),
      .rem_in   (cell_rem[i]),
      .quo_in   (cell_quo[i]),
      .dsr_in   (cell_dsr[i]),
      .early_in (cell_early[i]),
      .ctl      (cell_ctl[i+1]),
      .rem      (cell_rem[i+1]),
      .quo      (cell_quo[i+1]),
      .dsr      (cell_dsr[i+1]),
      .early    (cell_early[i+1])
    );
  end

  always_comb begin
    fin = cell_ctl[WIDTH];
    case (fin.mode)
      MODE_ADD, MODE_SUB, MODE_MUL: value_next = cell_early[WIDTH];
      MODE_DIV: value_next = fin.neg_q ? -cell_quo[WIDTH] : cell_quo[WIDTH];
      MODE_REM: value_next = fin.neg_r ? -cell_rem[WIDTH] : cell_rem[WIDTH];
      default:  value_next = '0;
    endcase
    if (fin.status != ST_OK) value_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= fin.valid;
    end
    if (adv) begin
      value  <= value_next;
      status <= fin.status;
    end
  end

  assign m_axis_tdata = OUT_W'(value);
  assign m_axis_tuser = status;

endmodule

[design/csa_checker.sv]
// ----------------------------------------------------------------------------
// csa_checker: port-level checks for the checked signed ALU
// Watches the output word and handshake of the top level.
// ----------------------------------------------------------------------------
module csa_checker #(
  parameter int WIDTH = csa_pkg::WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [((WIDTH+7)/8)*8-1:0]    m_axis_tdata,
  input logic [csa_pkg::ST_W-1:0]      m_axis_tuser
);
  import csa_pkg::*;

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_OVF ||
                       m_axis_tuser == ST_DIVZ))
    else $error("bad status code");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
    else $error("nonzero value with error status");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output word changed");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind checked_signed_alu csa_checker #(.WIDTH(WIDTH)) u_csa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
